/* hdl/srsm_pkg.sv */
// sector range smoother: shared types, constants and register codes
// no dependencies; used by every file in hdl
`default_nettype none

package srsm_pkg;

  localparam int SECTORS_DEF        = 8;
  localparam int SCAN_POINTS_DEF    = 360;
  localparam int SECTOR_SPACING_DEF = 45;

  localparam int RANGE_W = 16;
  localparam int ANGLE_W = 9;
  localparam int HW_W    = 6;
  localparam int SUM_W   = 23;
  localparam int COUNT_W = 7;
  localparam int INDEX_W = 3;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 7'd127;
  localparam int DIV_STEPS = SUM_W;

  localparam logic [15:0]     ALERT_DISTANCE_RST = 16'd300;
  localparam logic [15:0]     NEW_WEIGHT_RST     = 16'd58982;
  localparam logic [HW_W-1:0] HALF_WIDTH_RST     = 6'd20;
  localparam logic [15:0]     MIN_VALID_RST      = 16'd120;
  localparam logic [15:0]     MAX_VALID_RST      = 16'd12000;

  typedef enum logic [2:0] {
    REG_ALERT_DISTANCE = 3'd0,
    REG_NEW_WEIGHT     = 3'd1,
    REG_HALF_WIDTH     = 3'd2,
    REG_MIN_VALID      = 3'd3,
    REG_MAX_VALID      = 3'd4
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_ACCUM,
    ST_START,
    ST_DIV,
    ST_MUL,
    ST_ADD,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic [SUM_W-1:0]   sum;
    logic [COUNT_W-1:0] count;
    logic [RANGE_W-1:0] smooth;
  } cell_data_t;

  typedef struct packed {
    logic               valid;
    logic [RANGE_W-1:0] range;
    logic [ANGLE_W-1:0] angle;
  } sample_t;

endpackage

`default_nettype wire

/* hdl/srsm_cell.sv */
// one sector cell: window test, sum and count, smoothed range, shift link
// depends on srsm_pkg
`default_nettype none

module srsm_cell #(
  parameter int K              = 0,
  parameter int SCAN_POINTS    = srsm_pkg::SCAN_POINTS_DEF,
  parameter int SECTOR_SPACING = srsm_pkg::SECTOR_SPACING_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire srsm_pkg::sample_t              sample,
  input  wire logic [srsm_pkg::HW_W-1:0]      half_width,
  input  wire logic                           shift,
  input  wire srsm_pkg::cell_data_t           shift_in,
  output srsm_pkg::cell_data_t                data
);

  localparam int CENTRE = (K * SECTOR_SPACING) % SCAN_POINTS;
  localparam int WW     = $clog2(2 * SCAN_POINTS + 64);

  logic [WW-1:0] v0;
  logic [WW-1:0] v1;
  logic [WW-1:0] off;
  logic          wide;
  logic          hit;

  always_comb begin
    v0   = WW'(sample.angle) + WW'(SCAN_POINTS - CENTRE) + WW'(half_width);
    v1   = (v0 >= WW'(SCAN_POINTS)) ? v0 - WW'(SCAN_POINTS) : v0;
    off  = (v1 >= WW'(SCAN_POINTS)) ? v1 - WW'(SCAN_POINTS) : v1;
    wide = 32'({half_width, 1'b0}) >= 32'(SCAN_POINTS);
    hit  = wide || (off < WW'({half_width, 1'b0}));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      data <= '0;
    end else if (shift) begin
      data <= shift_in;
    end else if (sample.valid && hit && data.count != srsm_pkg::COUNT_MAX) begin
      data.sum   <= data.sum + srsm_pkg::SUM_W'(sample.range);
      data.count <= data.count + 1'b1;
    end
  end

endmodule

`default_nettype wire

/* hdl/srsm_div.sv */
// restoring divider, one quotient bit per cycle, for the sector mean
// depends on srsm_pkg
`default_nettype none

module srsm_div (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  input  wire logic [srsm_pkg::SUM_W-1:0]     num,
  input  wire logic [srsm_pkg::COUNT_W-1:0]   den,
  output logic                                done,
  output logic [srsm_pkg::SUM_W-1:0]          quot
);

  localparam int CW = $clog2(srsm_pkg::DIV_STEPS + 1);

  logic                          busy;
  logic [CW-1:0]                 cnt;
  logic [srsm_pkg::COUNT_W-1:0]  rem;
  logic [srsm_pkg::COUNT_W-1:0]  dreg;
  logic [srsm_pkg::COUNT_W:0]    rem_sh;
  logic [srsm_pkg::COUNT_W:0]    rem_sub;
  logic                          qbit;

  always_comb begin
    rem_sh  = {rem, quot[srsm_pkg::SUM_W-1]};
    qbit    = rem_sh >= {1'b0, dreg};
    rem_sub = rem_sh - {1'b0, dreg};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && cnt == CW'(1);
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(srsm_pkg::DIV_STEPS);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot <= num;
      rem  <= '0;
      dreg <= den;
    end else if (busy) begin
      quot <= {quot[srsm_pkg::SUM_W-2:0], qbit};
      rem  <= qbit ? rem_sub[srsm_pkg::COUNT_W-1:0] : rem_sh[srsm_pkg::COUNT_W-1:0];
    end
  end

endmodule

`default_nettype wire

/* hdl/sector_range_smoother.sv */
// sector range smoother top: sample register, chain of sector cells, divider and blend
// input: a sample beat is registered in the sample register, then added into its sector cells
// throughput: one sample beat per cycle within a scan; after a scan end beat the input is
// held while sectors pass start, divide, multiply, add and emit, and while output stalls
// reset: synchronous; sums, counts and smoothed ranges zero, registers to defaults
// depends on srsm_pkg, srsm_cell, srsm_div
`default_nettype none

module sector_range_smoother #(
  parameter int SECTORS        = srsm_pkg::SECTORS_DEF,
  parameter int SCAN_POINTS    = srsm_pkg::SCAN_POINTS_DEF,
  parameter int SECTOR_SPACING = srsm_pkg::SECTOR_SPACING_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // sample_range, sample_angle
  input  wire logic        s_axis_tlast,   // scan_end
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,   // sector_index, smoothed_range
  output logic             m_axis_tuser,   // too_close
  output logic             m_axis_tlast,   // last_sector
  input  wire logic        cfg_write,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  localparam int IW = $clog2(SECTORS);

  logic [15:0]                  alert_distance;
  logic [15:0]                  new_weight;
  logic [srsm_pkg::HW_W-1:0]    half_width;
  logic [15:0]                  min_valid;
  logic [15:0]                  max_valid;

  srsm_pkg::state_t             state;
  srsm_pkg::state_t             state_next;
  srsm_pkg::sample_t            smp;
  logic                         smp_end;
  logic [IW-1:0]                idx;
  logic                         in_beat;
  logic                         div_start;
  logic                         shift;
  logic                         out_load;
  logic                         idx_last;

  srsm_pkg::cell_data_t         chain [SECTORS];
  srsm_pkg::cell_data_t         tail_in;
  srsm_pkg::cell_data_t         head;

  logic                         div_done;
  logic [srsm_pkg::SUM_W-1:0]   div_num;
  logic [srsm_pkg::SUM_W-1:0]   div_quot;
  logic [15:0]                  mean;
  logic signed [16:0]           diff;
  logic signed [33:0]           prod;
  logic signed [33:0]           acc;
  logic [15:0]                  smooth_new;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      alert_distance <= srsm_pkg::ALERT_DISTANCE_RST;
      new_weight     <= srsm_pkg::NEW_WEIGHT_RST;
      half_width     <= srsm_pkg::HALF_WIDTH_RST;
      min_valid      <= srsm_pkg::MIN_VALID_RST;
      max_valid      <= srsm_pkg::MAX_VALID_RST;
    end else if (cfg_write) begin
      case (srsm_pkg::cfg_reg_t'(cfg_index))
        srsm_pkg::REG_ALERT_DISTANCE: alert_distance <= cfg_data;
        srsm_pkg::REG_NEW_WEIGHT:     new_weight     <= cfg_data;
        srsm_pkg::REG_HALF_WIDTH:     half_width     <= cfg_data[srsm_pkg::HW_W-1:0];
        srsm_pkg::REG_MIN_VALID:      min_valid      <= cfg_data;
        srsm_pkg::REG_MAX_VALID:      max_valid      <= cfg_data;
        default: ;
      endcase
    end
  end

  // input beat register
  assign s_axis_tready = (state == srsm_pkg::ST_ACCUM) && !smp_end;
  assign in_beat       = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      smp.valid <= 1'b0;
      smp_end   <= 1'b0;
    end else begin
      smp.valid <= in_beat && (32'(s_axis_tdata[24:16]) < 32'(SCAN_POINTS))
                   && (s_axis_tdata[15:0] > min_valid) && (s_axis_tdata[15:0] < max_valid);
      smp_end   <= in_beat && s_axis_tlast;
    end
    if (in_beat) begin
      smp.range <= s_axis_tdata[15:0];
      smp.angle <= s_axis_tdata[24:16];
    end
  end

  // sector cells, head at cell 0, results shifted back in at the tail
  assign tail_in = '{sum: '0, count: '0, smooth: smooth_new};
  assign head    = chain[0];

  for (genvar k = 0; k < SECTORS; k++) begin : g_cell
    srsm_pkg::cell_data_t link;
    if (k == SECTORS - 1) begin : g_tail
      assign link = tail_in;
    end else begin : g_mid
      assign link = chain[k+1];
    end
    srsm_cell #(
      .K              (k),
      .SCAN_POINTS    (SCAN_POINTS),
      .SECTOR_SPACING (SECTOR_SPACING)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .sample     (smp),
      .half_width (half_width),
      .shift      (shift),
      .shift_in   (link),
      .data       (chain[k])
    );
  end

  // mean of the head sector
  assign div_num = head.sum + srsm_pkg::SUM_W'(head.count[srsm_pkg::COUNT_W-1:1]);

  srsm_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (head.count),
    .done  (div_done),
    .quot  (div_quot)
  );

  // blend: old + w * (mean - old), rounded
  always_comb begin
    mean = (head.count == '0) ? 16'd0 : div_quot[15:0];
    diff = $signed({1'b0, mean}) - $signed({1'b0, head.smooth});
    acc  = $signed({2'b00, head.smooth, 16'h0000}) + prod + 34'sd32768;
  end

  always_ff @(posedge clk) begin
    if (state == srsm_pkg::ST_MUL) begin
      prod <= $signed({1'b0, new_weight}) * diff;
    end
    if (state == srsm_pkg::ST_ADD) begin
      smooth_new <= acc[31:16];
    end
  end

  // sequencer
  assign idx_last = idx == IW'(SECTORS - 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= srsm_pkg::ST_ACCUM;
      idx   <= '0;
    end else begin
      state <= state_next;
      if (out_load) begin
        idx <= idx_last ? '0 : idx + 1'b1;
      end
    end
  end

  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    shift      = 1'b0;
    out_load   = 1'b0;
    case (state)
      srsm_pkg::ST_ACCUM: begin
        if (smp_end) begin
          state_next = srsm_pkg::ST_START;
        end
      end
      srsm_pkg::ST_START: begin
        div_start  = 1'b1;
        state_next = srsm_pkg::ST_DIV;
      end
      srsm_pkg::ST_DIV: begin
        if (div_done) begin
          state_next = srsm_pkg::ST_MUL;
        end
      end
      srsm_pkg::ST_MUL: begin
        state_next = srsm_pkg::ST_ADD;
      end
      srsm_pkg::ST_ADD: begin
        state_next = srsm_pkg::ST_EMIT;
      end
      srsm_pkg::ST_EMIT: begin
        if (!m_axis_tvalid || m_axis_tready) begin
          out_load   = 1'b1;
          shift      = 1'b1;
          state_next = idx_last ? srsm_pkg::ST_ACCUM : srsm_pkg::ST_START;
        end
      end
      default: begin
        state_next = srsm_pkg::ST_ACCUM;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_axis_tdata <= {5'b00000, smooth_new, srsm_pkg::INDEX_W'(idx)};
      m_axis_tuser <= smooth_new < alert_distance;
      m_axis_tlast <= idx_last;
    end
  end

`ifndef SYNTHESIS
  a_ready_only_accum: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> state == srsm_pkg::ST_ACCUM)
    else $error("input ready outside accumulation");

  a_end_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (in_beat && s_axis_tlast) |=> !s_axis_tready)
    else $error("input taken after scan end beat");

  a_mul_after_div: assert property (@(posedge clk) disable iff (rst)
    (state == srsm_pkg::ST_MUL) |-> $past(state == srsm_pkg::ST_DIV) && $past(div_done))
    else $error("blend started before division finished");

  a_last_is_top_sector: assert property (@(posedge clk) disable iff (rst)
    (out_load && idx_last) |=> m_axis_tlast && state == srsm_pkg::ST_ACCUM)
    else $error("last sector beat out of step");
`endif

endmodule

`default_nettype wire

/* verif/sector_range_smoother_tb.sv */
// self-checking testbench for sector_range_smoother: sample beats in, per-sector reports out
// scoreboard fed by an in-bench model of the sector sums, counts and smoothing
// depends on srsm_pkg and the hdl sources of sector_range_smoother
module sector_range_smoother_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_SECTORS  = 8;
  localparam int SCAN_LEN     = 360;
  localparam int SPACING      = 45;
  localparam int SETTLE_CYCLES = 300;
  localparam int HOLD_CYCLES  = 1000;

  typedef struct packed {
    logic [2:0]  sector;
    logic [15:0] range;
    logic        close;
    logic        last;
  } sector_report_t;

  typedef struct packed {
    logic [15:0] range;
    logic [8:0]  angle;
    logic        scan_end;
    logic        typed;
    logic [15:0] typed_range;
    logic        typed_close;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;
  logic        m_tuser;
  logic        m_tlast;
  logic        cfg_write = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  bit tx_idle = 1'b1;
  bit rx_idle = 1'b1;
  bit hold_request = 1'b0;
  int mismatches = 0;

  // model state
  logic [15:0] cfg_alert;
  logic [15:0] cfg_weight;
  logic [5:0]  cfg_half;
  logic [15:0] cfg_min;
  logic [15:0] cfg_max;
  logic [22:0] acc_sum [NUM_SECTORS];
  logic [6:0]  acc_count [NUM_SECTORS];
  logic [15:0] smooth_range [NUM_SECTORS];
  sector_report_t scan_reports [NUM_SECTORS];
  sector_report_t pending_reports [$];

  sector_range_smoother u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tlast  (s_tlast),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),
    .m_axis_tuser  (m_tuser),
    .m_axis_tlast  (m_tlast),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  function automatic bit in_sector(input int angle, input int k);
    int centre;
    int span;
    int off;
    centre = (k * SPACING) % SCAN_LEN;
    span = 2 * int'(cfg_half);
    if (span >= SCAN_LEN) return 1'b1;
    off = (angle + SCAN_LEN - centre + int'(cfg_half)) % SCAN_LEN;
    return off < span;
  endfunction

  function automatic logic [15:0] blend_range(input logic [15:0] old_r, input logic [15:0] mean);
    logic [63:0] acc;
    acc = (64'd65536 - cfg_weight) * old_r + cfg_weight * mean + 64'd32768;
    return acc[31:16];
  endfunction

  // accumulate one sample; on scan end fill scan_reports and clear the sums
  function automatic bit take_sample(input logic [15:0] r, input logic [8:0] a, input logic e);
    int unsigned mean;
    logic [15:0] s;
    if (a < SCAN_LEN && r > cfg_min && r < cfg_max) begin
      for (int k = 0; k < NUM_SECTORS; k++) begin
        if (in_sector(a, k) && acc_count[k] < srsm_pkg::COUNT_MAX) begin
          acc_sum[k] = acc_sum[k] + r;
          acc_count[k] = acc_count[k] + 7'd1;
        end
      end
    end
    if (!e) return 1'b0;
    for (int k = 0; k < NUM_SECTORS; k++) begin
      mean = 0;
      if (acc_count[k] != 0)
        mean = (int'(acc_sum[k]) + int'(acc_count[k]) / 2) / int'(acc_count[k]);
      s = blend_range(smooth_range[k], mean[15:0]);
      smooth_range[k] = s;
      scan_reports[k] = '{sector: 3'(k), range: s, close: s < cfg_alert,
                          last: k == NUM_SECTORS - 1};
      acc_sum[k] = '0;
      acc_count[k] = '0;
    end
    return 1'b1;
  endfunction

  task automatic write_reg(input srsm_pkg::cfg_reg_t idx, input logic [15:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      srsm_pkg::REG_ALERT_DISTANCE: cfg_alert = val;
      srsm_pkg::REG_NEW_WEIGHT:     cfg_weight = val;
      srsm_pkg::REG_HALF_WIDTH:     cfg_half = val[5:0];
      srsm_pkg::REG_MIN_VALID:      cfg_min = val;
      srsm_pkg::REG_MAX_VALID:      cfg_max = val;
      default: ;
    endcase
  endtask

  task automatic set_registers(input logic [15:0] alert, input logic [15:0] weight,
                               input logic [5:0] half, input logic [15:0] lo,
                               input logic [15:0] hi);
    write_reg(srsm_pkg::REG_ALERT_DISTANCE, alert);
    write_reg(srsm_pkg::REG_NEW_WEIGHT, weight);
    write_reg(srsm_pkg::REG_HALF_WIDTH, {10'd0, half});
    write_reg(srsm_pkg::REG_MIN_VALID, lo);
    write_reg(srsm_pkg::REG_MAX_VALID, hi);
    cfg_write <= 1'b0;
  endtask

  task automatic send_sample(input logic [15:0] r, input logic [8:0] a, input logic e,
                             input logic typed, input logic [15:0] typed_range,
                             input logic typed_close);
    int gap;
    sector_report_t rep;
    if (tx_idle && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 16);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {7'd0, a, r};
    s_tlast  <= e;
    do @(posedge clk); while (!s_tready);
    if (take_sample(r, a, e)) begin
      for (int k = 0; k < NUM_SECTORS; k++) begin
        if (typed)
          rep = '{sector: 3'(k), range: typed_range, close: typed_close,
                  last: k == NUM_SECTORS - 1};
        else
          rep = scan_reports[k];
        pending_reports.insert(pending_reports.size(), rep);
      end
    end
  endtask

  task automatic random_scans(input int n_items);
    logic [15:0] r;
    logic [8:0]  a;
    logic        e;
    for (int left = n_items; left > 0; left--) begin
      case ($urandom_range(0, 9))
        0: r = 16'h0000;
        1: r = 16'hFFFF;
        2, 3: r = 16'($urandom_range(0, 65535));
        default: begin
          if (int'(cfg_max) > int'(cfg_min) + 1)
            r = 16'($urandom_range(int'(cfg_min) + 1, int'(cfg_max) - 1));
          else
            r = 16'($urandom_range(0, 65535));
        end
      endcase
      a = ($urandom_range(0, 9) == 0) ? 9'($urandom_range(360, 511))
                                      : 9'($urandom_range(0, 359));
      e = (left == 1) || ($urandom_range(0, 7) == 0);
      send_sample(r, a, e, 1'b0, '0, 1'b0);
    end
  endtask

  task automatic wait_settled();
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // receiver: random stalls plus one long hold on request
  always @(posedge clk) begin : rx_ready
    int stall_left;
    int hold_left;
    if (rst) begin
      stall_left = 0;
      hold_left = 0;
      m_tready <= 1'b0;
    end else begin
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else if (rx_idle && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(0, 15);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : check_reports
    sector_report_t got;
    sector_report_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = '{sector: m_tdata[2:0], range: m_tdata[18:3], close: m_tuser, last: m_tlast};
      if (pending_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected beat: sector %0d range %0d close %0b last %0b",
                   got.sector, got.range, got.close, got.last);
      end else begin
        want = pending_reports.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp sector %0d range %0d close %0b last %0b, got %0d %0d %0b %0b",
                     want.sector, want.range, want.close, want.last,
                     got.sector, got.range, got.close, got.last);
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("FAIL sector_range_smoother");
    $finish;
  end

  initial begin : main_seq
    stim_row_t directed [20];
    cfg_alert  = srsm_pkg::ALERT_DISTANCE_RST;
    cfg_weight = srsm_pkg::NEW_WEIGHT_RST;
    cfg_half   = srsm_pkg::HALF_WIDTH_RST;
    cfg_min    = srsm_pkg::MIN_VALID_RST;
    cfg_max    = srsm_pkg::MAX_VALID_RST;
    for (int k = 0; k < NUM_SECTORS; k++) begin
      acc_sum[k] = '0;
      acc_count[k] = '0;
      smooth_range[k] = '0;
    end

    // empty scans after reset read as zero with alert; window edges of sectors 0 and 1
    directed = '{
      '{16'd0,     9'd0,   1'b1, 1'b1, 16'd0, 1'b1},
      '{16'd65535, 9'd511, 1'b1, 1'b1, 16'd0, 1'b1},
      '{16'd121,   9'd0,   1'b0, 1'b0, 16'd0, 1'b0},
      '{16'd11999, 9'd359, 1'b0, 1'b0, 16'd0, 1'b0},
      '{16'd120,   9'd45,  1'b0, 1'b0, 16'd0, 1'b0},
      '{16'd12000, 9'd90,  1'b0, 1'b0, 16'd0, 1'b0},
      '{16'd5000,  9'd340, 1'b0, 1'b0, 16'd0, 1'b0},
      '{16'd6000,  9'd339, 1'b0, 1'b0, 16'd0, 1'b0},
      '{16'd7000,  9'd19,  1'b0, 1'b0, 16'd0, 1'b0},
      '{16'd7000,  9'd20,  1'b0, 1'b0, 16'd0, 1'b0},
      '{16'd2000,  9'd360, 1'b0, 1'b0, 16'd0, 1'b0},
      '{16'd3000,  9'd135, 1'b0, 1'b0, 16'd0, 1'b0},
      '{16'd4000,  9'd180, 1'b0, 1'b0, 16'd0, 1'b0},
      '{16'd4500,  9'd225, 1'b0, 1'b0, 16'd0, 1'b0},
      '{16'd250,   9'd270, 1'b0, 1'b0, 16'd0, 1'b0},
      '{16'd8000,  9'd315, 1'b1, 1'b0, 16'd0, 1'b0},
      '{16'd9000,  9'd65,  1'b0, 1'b0, 16'd0, 1'b0},
      '{16'd9000,  9'd25,  1'b0, 1'b0, 16'd0, 1'b0},
      '{16'd170,   9'd300, 1'b1, 1'b0, 16'd0, 1'b0},
      '{16'd65535, 9'd511, 1'b1, 1'b0, 16'd0, 1'b0}
    };

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    set_registers(srsm_pkg::ALERT_DISTANCE_RST, srsm_pkg::NEW_WEIGHT_RST,
                  srsm_pkg::HALF_WIDTH_RST, srsm_pkg::MIN_VALID_RST,
                  srsm_pkg::MAX_VALID_RST);
    foreach (directed[i])
      send_sample(directed[i].range, directed[i].angle, directed[i].scan_end,
                  directed[i].typed, directed[i].typed_range, directed[i].typed_close);
    s_tvalid <= 1'b0;
    wait_settled();

    // widest windows, full weight, widest band (only ranges 0 and 65535 out of band)
    set_registers(16'hFFFF, 16'hFFFF, 6'd63, 16'd0, 16'hFFFF);
    random_scans(20);
    s_tvalid <= 1'b0;
    wait_settled();

    // zero weight and empty windows: smoothed ranges must hold
    set_registers(16'd0, 16'd0, 6'd0, 16'hFFFF, 16'd0);
    random_scans(10);
    s_tvalid <= 1'b0;
    wait_settled();

    // back-pressure: hold the output while short scans keep coming
    set_registers(16'd20000, 16'd1, 6'd45, 16'd120, 16'd12000);
    hold_request = 1'b1;
    for (int i = 0; i < 12; i++)
      send_sample(16'($urandom_range(200, 11000)), 9'($urandom_range(0, 359)), i % 3 == 2,
                  1'b0, '0, 1'b0);
    s_tvalid <= 1'b0;
    wait_settled();

    set_registers(16'($urandom_range(0, 65535)), 16'($urandom_range(1, 65535)),
                  6'($urandom_range(0, 45)), 16'($urandom_range(0, 2000)),
                  16'($urandom_range(3000, 65535)));
    random_scans(20);
    s_tvalid <= 1'b0;
    wait_settled();

    set_registers(16'($urandom_range(0, 65535)), 16'($urandom_range(1, 65535)),
                  6'($urandom_range(0, 45)), 16'($urandom_range(0, 2000)),
                  16'($urandom_range(3000, 65535)));
    random_scans(15);
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    random_scans(15);
    s_tvalid <= 1'b0;
    wait_settled();

    if (mismatches == 0)
      $display("PASS sector_range_smoother");
    else
      $display("FAIL sector_range_smoother");
    $finish;
  end

endmodule
